// File: design/w2s_pkg.sv
// shared types, codes and constants for the world-to-screen projector
`timescale 1ns / 1ps
package w2s_pkg;

  localparam int COORD_FRAC_BITS_DEF = 24;
  localparam int COORD_WIDTH_DEF     = 48;
  localparam int NUM_COEFS           = 12;
  localparam int SIZE_W              = 14;
  localparam int SCR_W               = 23;
  localparam int DIGIT_W             = 2;
  localparam int DIV_STEPS           = 26;
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = 14'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = 14'd1080;
  localparam logic signed [SCR_W-1:0] SCR_MAX = 23'sh3FFFFF;
  localparam logic signed [SCR_W-1:0] SCR_MIN = 23'sh400000;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_PROJECT = 2'd1,
    MODE_INVAL   = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_ON_SCREEN  = 3'd0,
    ST_NO_MATRIX  = 3'd1,
    ST_BEHIND     = 3'd2,
    ST_OFF_SCREEN = 3'd3,
    ST_CMD_OK     = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_RD_CONST, S_INIT_ACC, S_RD_COEF, S_LD_COEF, S_MAC,
    S_ROW_DONE, S_CHECK, S_SC_INIT, S_SC_MUL, S_DIV_INIT, S_DIV, S_SC_STORE, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CAPTURE, OP_WRITE, OP_CLEAR, OP_ACC_INIT, OP_COEF_LD, OP_MAC,
    OP_ROW_STORE, OP_SC_INIT, OP_SC_MUL, OP_DIV_INIT, OP_DIV_STEP, OP_SC_STORE
  } dp_op_t;

  typedef struct packed {
    dp_op_t               op;
    logic [3:0]           ram_addr;
    logic [1:0]           row;
    logic [1:0]           col;
    logic [DIGIT_W-1:0]   digit;
    logic [3:0]           bitc;
    logic                 sel;
    status_t              code;
    logic                 out_load;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  idx_ok;
    logic  mask_full;
    logic  behind;
    logic  off_screen;
    logic  out_free;
  } stat_t;

endpackage

// File: design/world_to_screen_projector.sv
// top level: configuration registers, controller and datapath
`timescale 1ns / 1ps
// Projects world points to pixel coordinates through a 3x4 view-projection
// matrix loaded one coefficient per item (mode 0), cleared by mode 2. A
// project item (mode 1) returns status and rounded Q15.8 screen x/y. Load,
// invalidate, unused-mode and no-matrix items go from decode straight to the
// emit state. A project item with a full matrix runs the three mac rows and
// the behind/off-screen check; a rejected point is emitted from there, while
// an accepted point first passes x and then y through the scaler and divider.
// The single coefficient-by-16-bit-digit mac unit, the bit-serial size scaler
// and the restoring divider are shared, each coordinate using them in turn.
// One item is worked on at a time; the result register lets a new item in
// while the last result waits. Screen size writes of 0 or 1 are ignored.
module world_to_screen_projector #(
  parameter int COORD_WIDTH     = w2s_pkg::COORD_WIDTH_DEF,
  parameter int COORD_FRAC_BITS = w2s_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    mode,
  input  logic [3:0]                    coef_index,
  input  logic signed [COORD_WIDTH-1:0] coef_value,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    status,
  output logic signed [22:0]            screen_x,
  output logic signed [22:0]            screen_y
);
  import w2s_pkg::*;

  logic [SIZE_W-1:0] screen_width, screen_height;
  logic [SIZE_W-1:0] wval;
  cmd_t              cmd;
  stat_t             stat;

  assign pready = 1'b1;
  assign wval   = pwdata[SIZE_W-1:0];
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(screen_height) : 32'(screen_width);

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && pready && wval > SIZE_W'(1)) begin
      if (paddr[2] == REG_WIDTH) begin
        screen_width <= wval;
      end else begin
        screen_height <= wval;
      end
    end
  end

  w2s_ctrl #(.COORD_WIDTH(COORD_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  w2s_dp #(.COORD_WIDTH(COORD_WIDTH), .COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .coef_index    (coef_index),
    .coef_value    (coef_value),
    .point_x       (point_x),
    .point_y       (point_y),
    .point_z       (point_z),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .status        (status),
    .screen_x      (screen_x),
    .screen_y      (screen_y)
  );
endmodule

// File: design/w2s_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module w2s_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 12,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/w2s_dp.sv
// projector datapath: coefficient store, mac, range checks, scaler and divider
`timescale 1ns / 1ps
module w2s_dp #(
  parameter int COORD_WIDTH     = w2s_pkg::COORD_WIDTH_DEF,
  parameter int COORD_FRAC_BITS = w2s_pkg::COORD_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  w2s_pkg::cmd_t                 cmd,
  output w2s_pkg::stat_t                stat,
  input  logic [1:0]                    mode,
  input  logic [3:0]                    coef_index,
  input  logic signed [COORD_WIDTH-1:0] coef_value,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic [w2s_pkg::SIZE_W-1:0]    screen_width,
  input  logic [w2s_pkg::SIZE_W-1:0]    screen_height,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic [2:0]                    status,
  output logic signed [w2s_pkg::SCR_W-1:0] screen_x,
  output logic signed [w2s_pkg::SCR_W-1:0] screen_y
);
  import w2s_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int ND  = (CW + 15) / 16;
  localparam int PW  = ND * 16;
  localparam int CLW = 2 * CW + 2;
  localparam int AW  = CLW + 1;
  localparam int MW  = AW + SIZE_W;
  localparam int NW  = CLW + 24;
  localparam int DVW = CLW + 26;
  localparam int CKW = CLW + 5;

  logic [1:0]             cap_mode;
  logic [3:0]             cap_idx;
  logic signed [CW-1:0]   cap_value, cap_x, cap_y, cap_z;
  logic [NUM_COEFS-1:0]   mask;
  logic [CW-1:0]          rdata;
  logic signed [CW-1:0]   coef_reg;
  logic signed [CLW-1:0]  acc, clip_x, clip_y, clip_w;
  logic signed [AW-1:0]   a_reg;
  logic signed [MW-1:0]   m_reg;
  logic                   neg;
  logic [DVW-1:0]         rem, dvs;
  logic [DIV_STEPS-1:0]   q;
  logic signed [SCR_W-1:0] sx, sy;

  logic                   idx_ok;
  logic signed [CW-1:0]   p_sel;
  logic signed [PW-1:0]   p_ext;
  logic [15:0]            chunk;
  logic signed [16:0]     dig;
  logic signed [CW+16:0]  prod;
  logic signed [CKW-1:0]  wk, xk, yk, w20, one_q, t13, t10x, t10y;
  logic signed [AW-1:0]   a_sel;
  logic [SIZE_W-1:0]      scale_sel;
  logic signed [NW-1:0]   num;
  logic [NW-1:0]          mag;
  logic [DIV_STEPS:0]     qq;
  logic signed [SCR_W-1:0] v;

  assign idx_ok = cap_idx < 4'(NUM_COEFS);

  w2s_ram #(.WIDTH(CW), .DEPTH(NUM_COEFS)) u_coefs (
    .clk   (clk),
    .we    (cmd.op == OP_WRITE && idx_ok),
    .waddr (cap_idx),
    .wdata (cap_value),
    .raddr (cmd.ram_addr),
    .rdata (rdata)
  );

  // one 16-bit digit of the point per mac cycle, top digit signed
  always_comb begin
    case (cmd.col)
      2'd0:    p_sel = cap_x;
      2'd1:    p_sel = cap_y;
      default: p_sel = cap_z;
    endcase
    p_ext = PW'(p_sel);
    chunk = p_ext[16*cmd.digit +: 16];
    if (cmd.digit == DIGIT_W'(ND - 1)) begin
      dig = $signed({chunk[15], chunk});
    end else begin
      dig = $signed({1'b0, chunk});
    end
    prod = coef_reg * dig;
  end

  // exact tests: 20w <= 1, 10|x| > 13w
  always_comb begin
    wk    = CKW'(clip_w);
    xk    = CKW'(clip_x);
    yk    = CKW'(clip_y);
    w20   = (wk <<< 4) + (wk <<< 2);
    one_q = $signed({{(CKW-1){1'b0}}, 1'b1} << (2 * COORD_FRAC_BITS));
    t13   = (wk <<< 3) + (wk <<< 2) + wk;
    t10x  = (xk <<< 3) + (xk <<< 1);
    t10y  = (yk <<< 3) + (yk <<< 1);
  end

  always_comb begin
    if (cmd.sel) begin
      a_sel     = AW'(clip_w) - AW'(clip_y);
      scale_sel = screen_height;
    end else begin
      a_sel     = AW'(clip_x) + AW'(clip_w);
      scale_sel = screen_width;
    end
    num = (NW'(m_reg) <<< 8) + NW'(clip_w);
    mag = num[NW-1] ? NW'(-num) : NW'(num);
    qq  = {1'b0, q} + (DIV_STEPS+1)'(neg && (rem != '0));
    if (q[DIV_STEPS-1]) begin
      v = neg ? SCR_MIN : SCR_MAX;
    end else if (neg) begin
      v = (qq > (DIV_STEPS+1)'(4194304)) ? SCR_MIN : -$signed(SCR_W'(qq));
    end else begin
      v = ({1'b0, q} > (DIV_STEPS+1)'(4194303)) ? SCR_MAX : $signed(SCR_W'(q));
    end
  end

  assign stat.mode       = mode_t'(cap_mode);
  assign stat.idx_ok     = idx_ok;
  assign stat.mask_full  = &mask;
  assign stat.behind     = w20 <= one_q;
  assign stat.off_screen = (t10x > t13) || (t10x < -t13) || (t10y > t13) || (t10y < -t13);
  assign stat.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_WRITE && idx_ok) begin
        mask[cap_idx] <= 1'b1;
      end else if (cmd.op == OP_CLEAR) begin
        mask <= '0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        cap_mode  <= mode;
        cap_idx   <= coef_index;
        cap_value <= coef_value;
        cap_x     <= point_x;
        cap_y     <= point_y;
        cap_z     <= point_z;
      end
      OP_ACC_INIT: acc <= CLW'($signed(rdata)) <<< COORD_FRAC_BITS;
      OP_COEF_LD:  coef_reg <= $signed(rdata);
      OP_MAC:      acc <= acc + (CLW'(prod) <<< (16 * cmd.digit));
      OP_ROW_STORE: begin
        case (cmd.row)
          2'd0:    clip_x <= acc;
          2'd1:    clip_y <= acc;
          default: clip_w <= acc;
        endcase
      end
      OP_SC_INIT: begin
        a_reg <= a_sel;
        m_reg <= '0;
      end
      OP_SC_MUL: m_reg <= (m_reg <<< 1) + (scale_sel[cmd.bitc] ? MW'(a_reg) : MW'(0));
      OP_DIV_INIT: begin
        neg <= num[NW-1];
        rem <= DVW'(mag);
        dvs <= DVW'($unsigned(clip_w)) << 26;
        q   <= '0;
      end
      OP_DIV_STEP: begin
        if (rem >= dvs) begin
          rem <= rem - dvs;
          q   <= {q[DIV_STEPS-2:0], 1'b1};
        end else begin
          q   <= {q[DIV_STEPS-2:0], 1'b0};
        end
        dvs <= dvs >> 1;
      end
      OP_SC_STORE: begin
        if (cmd.sel) begin
          sy <= v;
        end else begin
          sx <= v;
        end
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      status <= cmd.code;
      if (cmd.code == ST_ON_SCREEN) begin
        screen_x <= sx;
        screen_y <= sy;
      end else begin
        screen_x <= '0;
        screen_y <= '0;
      end
    end
  end
endmodule

// File: design/w2s_ctrl.sv
// projector controller: sequences loads, mac rows, checks, scaling and division
`timescale 1ns / 1ps
module w2s_ctrl #(
  parameter int COORD_WIDTH = w2s_pkg::COORD_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  w2s_pkg::stat_t stat,
  output w2s_pkg::cmd_t  cmd
);
  import w2s_pkg::*;

  localparam int ND = (COORD_WIDTH + 15) / 16;

  state_t             state, state_next;
  logic [1:0]         row, col;
  logic [DIGIT_W-1:0] digit;
  logic [3:0]         bitc;
  logic [4:0]         stepc;
  logic               sel;
  status_t            res_code;
  logic               last_digit;

  assign last_digit = digit == DIGIT_W'(ND - 1);
  assign in_stall   = state != S_IDLE;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (in_valid) state_next = S_DECODE;
      S_DECODE: begin
        if (stat.mode == MODE_PROJECT && stat.mask_full) begin
          state_next = S_RD_CONST;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_RD_CONST: state_next = S_INIT_ACC;
      S_INIT_ACC: state_next = S_RD_COEF;
      S_RD_COEF:  state_next = S_LD_COEF;
      S_LD_COEF:  state_next = S_MAC;
      S_MAC: begin
        if (last_digit) state_next = (col == 2'd2) ? S_ROW_DONE : S_RD_COEF;
      end
      S_ROW_DONE: state_next = (row == 2'd2) ? S_CHECK : S_RD_CONST;
      S_CHECK:    state_next = (stat.behind || stat.off_screen) ? S_EMIT : S_SC_INIT;
      S_SC_INIT:  state_next = S_SC_MUL;
      S_SC_MUL:   if (bitc == 4'd0) state_next = S_DIV_INIT;
      S_DIV_INIT: state_next = S_DIV;
      S_DIV:      if (stepc == 5'(DIV_STEPS - 1)) state_next = S_SC_STORE;
      S_SC_STORE: state_next = sel ? S_EMIT : S_SC_INIT;
      S_EMIT:     if (stat.out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.row      = row;
    cmd.col      = col;
    cmd.digit    = digit;
    cmd.bitc     = bitc;
    cmd.sel      = sel;
    cmd.code     = res_code;
    cmd.ram_addr = {row, col};
    unique case (state)
      S_IDLE:     if (in_valid) cmd.op = OP_CAPTURE;
      S_DECODE: begin
        if (stat.mode == MODE_LOAD) begin
          cmd.op = OP_WRITE;
        end else if (stat.mode == MODE_INVAL) begin
          cmd.op = OP_CLEAR;
        end
      end
      S_RD_CONST: cmd.ram_addr = {row, 2'd3};
      S_INIT_ACC: cmd.op = OP_ACC_INIT;
      S_LD_COEF:  cmd.op = OP_COEF_LD;
      S_MAC:      cmd.op = OP_MAC;
      S_ROW_DONE: cmd.op = OP_ROW_STORE;
      S_SC_INIT:  cmd.op = OP_SC_INIT;
      S_SC_MUL:   cmd.op = OP_SC_MUL;
      S_DIV_INIT: cmd.op = OP_DIV_INIT;
      S_DIV:      cmd.op = OP_DIV_STEP;
      S_SC_STORE: cmd.op = OP_SC_STORE;
      S_EMIT:     cmd.out_load = stat.out_free;
      default:    cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      row      <= '0;
      col      <= '0;
      digit    <= '0;
      bitc     <= '0;
      stepc    <= '0;
      sel      <= 1'b0;
      res_code <= ST_CMD_OK;
    end else begin
      state <= state_next;
      case (state)
        S_DECODE: begin
          row <= '0;
          if (stat.mode != MODE_PROJECT) begin
            res_code <= ST_CMD_OK;
          end else if (!stat.mask_full) begin
            res_code <= ST_NO_MATRIX;
          end
        end
        S_INIT_ACC: col <= '0;
        S_LD_COEF:  digit <= '0;
        S_MAC: begin
          if (last_digit) begin
            col <= col + 2'd1;
          end else begin
            digit <= digit + DIGIT_W'(1);
          end
        end
        S_ROW_DONE: row <= row + 2'd1;
        S_CHECK: begin
          sel <= 1'b0;
          if (stat.behind) begin
            res_code <= ST_BEHIND;
          end else if (stat.off_screen) begin
            res_code <= ST_OFF_SCREEN;
          end
        end
        S_SC_INIT:  bitc <= 4'(SIZE_W - 1);
        S_SC_MUL:   bitc <= bitc - 4'd1;
        S_DIV_INIT: stepc <= '0;
        S_DIV:      stepc <= stepc + 5'd1;
        S_SC_STORE: begin
          sel <= 1'b1;
          if (sel) res_code <= ST_ON_SCREEN;
        end
        default: ;
      endcase
    end
  end
endmodule
